FILE: hw/rtl/spa_pkg.sv
// Shared types and constants for the slot pool allocator.
`timescale 1ns / 1ps

package spa_pkg;

	localparam int SLOT_W  = 6;
	localparam int RANK_W  = 6;
	localparam int ID_W    = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_MISS    = 2'd1,
		STATUS_BADFREE = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot_index;
		logic [RANK_W-1:0] live_rank;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot_out;
		logic [ID_W-1:0]    entity_id;
		logic [COUNT_W-1:0] live_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_SCAN,
		S_FREE_CHK,
		S_DONE
	} state_t;

endpackage

FILE: hw/rtl/slot_pool_allocator_unit.sv
// Top level of the first-fit bitmap slot allocator.
`timescale 1ns / 1ps

// channel | dir | handshake            | word
// --------+-----+----------------------+----------------------------------------
// req     | in  | req_valid/req_stall  | cmd, slot_index, live_rank
// rsp     | out | rsp_valid/rsp_stall  | status, slot_out, entity_id, live_count
//
// Scan: alloc and lookup walk the used bitmap one slot per cycle through the
//   single read port of the bitmap memory in S_SCAN, then pass S_DONE. Full
//   pool or out-of-range rank goes straight to S_DONE, free via S_FREE_CHK.
// Clear writes zero over the bitmap, one entry per cycle, in S_SWEEP.
// Reset: after arst_n releases, a clearing pass over every slot runs
//   with req_stall high before the first word is taken.
// Stalls: one result register; req is taken again while a result waits, and a
//   finished item parks in S_DONE until the result register frees up.

module slot_pool_allocator_unit #(
	parameter int POOL_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  spa_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output spa_pkg::rsp_t rsp
);

	import spa_pkg::*;

	localparam int IDXW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNTW = $clog2(POOL_SLOTS + 1);
	localparam int CMPW = (CNTW > RANK_W) ? CNTW : RANK_W;

	// used bitmap, one bit per slot
	logic used_mem [POOL_SLOTS];

	state_t            state_q, state_d;
	logic [CNTW-1:0]   scan_q, scan_d;
	logic [RANK_W-1:0] seen_q, seen_d;
	logic [CNTW-1:0]   used_total_q, used_total_d;
	logic [ID_W-1:0]   next_id_q, next_id_d;
	logic              sweep_rsp_q, sweep_rsp_d;
	req_t              op_q, op_d;
	rsp_t              res_q, res_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q, rsp_valid_d;

	// read pipeline: address issued, the registered bit comes back in the following cycle
	logic              chk_valid_s1, chk_valid_d;
	logic [IDXW-1:0]   chk_idx_s1;
	logic              rd_bit_s1;

	logic              mem_re;
	logic [IDXW-1:0]   mem_raddr;
	logic              mem_we;
	logic [IDXW-1:0]   mem_waddr;
	logic              mem_wdata;
	logic              out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			used_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_bit_s1 <= used_mem[mem_raddr];
		end
		chk_idx_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			scan_q       <= '0;
			seen_q       <= '0;
			used_total_q <= '0;
			next_id_q    <= ID_W'(1);
			sweep_rsp_q  <= 1'b0;
			rsp_valid_q  <= 1'b0;
			chk_valid_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			scan_q       <= scan_d;
			seen_q       <= seen_d;
			used_total_q <= used_total_d;
			next_id_q    <= next_id_d;
			sweep_rsp_q  <= sweep_rsp_d;
			rsp_valid_q  <= rsp_valid_d;
			chk_valid_s1 <= chk_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		res_q <= res_d;
		rsp_q <= rsp_d;
	end

	always_comb begin
		state_d      = state_q;
		scan_d       = scan_q;
		seen_d       = seen_q;
		used_total_d = used_total_q;
		next_id_d    = next_id_q;
		sweep_rsp_d  = sweep_rsp_q;
		op_d         = op_q;
		res_d        = res_q;
		rsp_d        = rsp_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		chk_valid_d  = 1'b0;
		mem_re       = 1'b0;
		mem_raddr    = scan_q[IDXW-1:0];
		mem_we       = 1'b0;
		mem_waddr    = chk_idx_s1;
		mem_wdata    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d       = req;
					res_d      = '0;
					res_d.status = STATUS_OK;
					scan_d     = '0;
					seen_d     = '0;
					unique case (req.cmd)
						CMD_ALLOC: begin
							// a non-full pool always has a free slot to find
							if (used_total_q == CNTW'(POOL_SLOTS)) begin
								res_d.status = STATUS_MISS;
								state_d      = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_LOOKUP: begin
							if (CMPW'(req.live_rank) >= CMPW'(used_total_q)) begin
								res_d.status = STATUS_MISS;
								state_d      = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_FREE: begin
							if (32'(req.slot_index) < 32'(POOL_SLOTS)) begin
								mem_re    = 1'b1;
								mem_raddr = IDXW'(req.slot_index);
								state_d   = S_FREE_CHK;
							end else begin
								res_d.status = STATUS_BADFREE;
								state_d      = S_DONE;
							end
						end
						CMD_CLEAR: begin
							sweep_rsp_d = 1'b1;
							state_d     = S_SWEEP;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = scan_q[IDXW-1:0];
				mem_wdata = 1'b0;
				scan_d    = scan_q + CNTW'(1);
				if (scan_q == CNTW'(POOL_SLOTS - 1)) begin
					used_total_d = '0;
					next_id_d    = ID_W'(1);
					sweep_rsp_d  = 1'b0;
					state_d      = sweep_rsp_q ? S_DONE : S_IDLE;
				end
			end

			S_SCAN: begin
				if (scan_q < CNTW'(POOL_SLOTS)) begin
					mem_re      = 1'b1;
					mem_raddr   = scan_q[IDXW-1:0];
					scan_d      = scan_q + CNTW'(1);
					chk_valid_d = 1'b1;
				end
				if (chk_valid_s1) begin
					if (op_q.cmd == CMD_ALLOC) begin
						if (!rd_bit_s1) begin
							mem_we          = 1'b1;
							mem_waddr       = chk_idx_s1;
							mem_wdata       = 1'b1;
							used_total_d    = used_total_q + CNTW'(1);
							next_id_d       = next_id_q + ID_W'(1);
							res_d.slot_out  = SLOT_W'(chk_idx_s1);
							res_d.entity_id = next_id_q;
							chk_valid_d     = 1'b0;
							state_d         = S_DONE;
						end
					end else if (rd_bit_s1) begin
						if (seen_q == op_q.live_rank) begin
							res_d.slot_out = SLOT_W'(chk_idx_s1);
							chk_valid_d    = 1'b0;
							state_d        = S_DONE;
						end else begin
							seen_d = seen_q + RANK_W'(1);
						end
					end
				end
			end

			S_FREE_CHK: begin
				if (rd_bit_s1) begin
					mem_we       = 1'b1;
					mem_waddr    = IDXW'(op_q.slot_index);
					mem_wdata    = 1'b0;
					used_total_d = used_total_q - CNTW'(1);
				end else begin
					res_d.status = STATUS_BADFREE;
				end
				state_d = S_DONE;
			end

			S_DONE: begin
				if (out_free) begin
					rsp_d            = res_q;
					rsp_d.live_count = COUNT_W'(used_total_q);
					rsp_valid_d      = 1'b1;
					state_d          = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/spa_checker.sv
// Port-level checks for the slot pool allocator, bound to the top level.
`timescale 1ns / 1ps

module spa_checker #(
	parameter int POOL_SLOTS = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input spa_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input spa_pkg::rsp_t rsp
);

	import spa_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_MISS ||
			rsp.status == STATUS_BADFREE))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STATUS_OK) |->
			(rsp.slot_out == '0 && rsp.entity_id == '0))
		else $error("failed word carries nonzero slot or id");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((POOL_SLOTS > 127) || (32'(rsp.live_count) <= 32'(POOL_SLOTS))))
		else $error("live count above pool size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken back to back");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result word changed");

endmodule

bind slot_pool_allocator_unit spa_checker #(.POOL_SLOTS(POOL_SLOTS)) u_spa_checker (.*);

FILE: tb/sv/slot_pool_allocator_unit_test.sv
// Self-checking testbench for the slot pool allocator: predictor, driver and monitor.
`timescale 1ns / 1ps

module slot_pool_allocator_unit_test;
	import spa_pkg::*;

	localparam int POOL_SLOTS   = 64;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_IDLE     = 10;

	// Mix of commands for one stretch of random words.
	typedef enum int {
		PH_FILL,   // mostly alloc, runs the pool into full
		PH_DRAIN,  // mostly frees of live slots
		PH_MIXED,  // everything, clear now and then
		PH_NOISE   // all fields random
	} phase_t;

	// Allocator state as the predictor tracks it.
	typedef struct {
		bit [POOL_SLOTS-1:0] used;
		bit [COUNT_W-1:0]    count;
		bit [ID_W-1:0]       next_id;
	} pool_t;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	req_t  pend_q[$];    // words waiting for the driver
	rsp_t  result_q[$];  // predicted results, oldest first
	pool_t live_pool;    // predictor state, advanced on each accepted word
	pool_t plan_pool;    // stimulus-side view, used to aim frees and lookups
	int    send_gap   = 0;
	int    stall_left = 0;
	int    err_count  = 0;
	bit    calm       = 1'b0;  // no idling on either side while set

	slot_pool_allocator_unit #(
		.POOL_SLOTS(POOL_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one word to a pool state and returns the result it yields.
	function automatic rsp_t pool_apply(inout pool_t s, input req_t w);
		rsp_t r;
		int   k;
		int   seen;
		r = '0;
		r.status = STATUS_OK;
		case (w.cmd)
			CMD_ALLOC: begin
				// first fit: lowest clear bit wins
				r.status = STATUS_MISS;
				for (k = 0; k < POOL_SLOTS; k++) begin
					if (!s.used[k]) begin
						s.used[k]  = 1'b1;
						r.status    = STATUS_OK;
						r.slot_out  = SLOT_W'(k);
						r.entity_id = s.next_id;
						s.next_id   = s.next_id + ID_W'(1);
						s.count     = s.count + COUNT_W'(1);
						break;
					end
				end
			end
			CMD_FREE: begin
				// a slot not in use (or past the pool) leaves state alone
				if (w.slot_index < POOL_SLOTS && s.used[w.slot_index]) begin
					s.used[w.slot_index] = 1'b0;
					s.count = s.count - COUNT_W'(1);
				end else begin
					r.status = STATUS_BADFREE;
				end
			end
			CMD_CLEAR: begin
				s.used    = '0;
				s.count   = '0;
				s.next_id = ID_W'(1);
			end
			CMD_LOOKUP: begin
				// rank counts live slots in ascending order
				r.status = STATUS_MISS;
				seen = 0;
				for (k = 0; k < POOL_SLOTS; k++) begin
					if (s.used[k]) begin
						if (seen == w.live_rank) begin
							r.status   = STATUS_OK;
							r.slot_out = SLOT_W'(k);
							break;
						end
						seen++;
					end
				end
			end
		endcase
		r.live_count = s.count;
		return r;
	endfunction

	// Queues one word and tracks its effect on the stimulus-side view.
	task automatic plan(cmd_t c, logic [SLOT_W-1:0] idx, logic [RANK_W-1:0] rank);
		req_t w;
		w.cmd        = c;
		w.slot_index = idx;
		w.live_rank  = rank;
		pend_q.push_back(w);
		void'(pool_apply(plan_pool, w));
	endtask

	// A slot that will be live when the word lands, or any slot if none is.
	function automatic logic [SLOT_W-1:0] pick_live_slot();
		int n;
		int k;
		if (plan_pool.count == 0)
			return SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
		n = $urandom_range(0, plan_pool.count - 1);
		for (k = 0; k < POOL_SLOTS; k++) begin
			if (plan_pool.used[k]) begin
				if (n == 0)
					return SLOT_W'(k);
				n--;
			end
		end
		return '0;
	endfunction

	// Mostly ranks in or just past the live range, sometimes anywhere.
	function automatic logic [RANK_W-1:0] pick_rank();
		if ($urandom_range(0, 3) == 0 || plan_pool.count >= POOL_SLOTS)
			return RANK_W'($urandom_range(0, 63));
		return RANK_W'($urandom_range(0, plan_pool.count));
	endfunction

	// Holds the sender back until every predicted result has come out.
	// Sampled mid-cycle so the driver's edge updates have settled.
	task automatic wait_drained();
		do @(negedge clk);
		while (pend_q.size() != 0 || req_valid || result_q.size() != 0);
	endtask

	// Driver: presents queued words, predicts each one as it is taken, then
	// draws an idle gap before the next. A gap of zero keeps valid high.
	always @(posedge clk or negedge arst_n) begin : drive
		int gap;
		bit slot_open;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  <= 0;
		end else begin
			gap       = send_gap;
			slot_open = !req_valid || !req_stall;
			if (req_valid && !req_stall) begin
				result_q.push_back(pool_apply(live_pool, req));
				gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (slot_open) begin
				if (gap == 0 && pend_q.size() > 0) begin
					req       <= pend_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
					if (gap > 0)
						gap--;
				end
			end
			send_gap <= gap;
		end
	end

	// Monitor: checks each taken result against the oldest prediction, then
	// stalls for a drawn number of cycles whether or not a result is waiting.
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		int   hold;
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			hold = stall_left;
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result word: status %0d slot %0d id %0h live %0d",
							rsp.status, rsp.slot_out, rsp.entity_id, rsp.live_count);
				end else begin
					want = result_q.pop_front();
					if (rsp.status !== want.status || rsp.slot_out !== want.slot_out ||
						rsp.entity_id !== want.entity_id || rsp.live_count !== want.live_count) begin
						err_count++;
						if (err_count <= 10)
							$display("mismatch (exp/got): status %0d/%0d slot %0d/%0d id %0h/%0h live %0d/%0d",
								want.status, rsp.status, want.slot_out, rsp.slot_out,
								want.entity_id, rsp.entity_id, want.live_count, rsp.live_count);
					end
				end
				hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
			end else if (hold > 0) begin
				hold--;
			end
			rsp_stall  <= (hold > 0);
			stall_left <= hold;
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		phase_t kind;
		int     sent;
		int     len;
		int     pct;
		int     i;
		bit     first;

		live_pool = '{used: '0, count: '0, next_id: 1};
		plan_pool = '{used: '0, count: '0, next_id: 1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty pool corner cases, first allocs, lookups in and past
		// the live range, double free, reuse of a freed hole, clear and restart.
		plan(CMD_LOOKUP, 6'd0, 6'd0);    // nothing live
		plan(CMD_FREE, 6'd0, 6'd63);     // free of an unused slot
		plan(CMD_FREE, 6'd63, 6'd0);
		plan(CMD_ALLOC, 6'd63, 6'd63);
		plan(CMD_ALLOC, 6'd0, 6'd0);
		plan(CMD_ALLOC, 6'd21, 6'd42);
		plan(CMD_ALLOC, 6'd42, 6'd21);
		plan(CMD_LOOKUP, 6'd63, 6'd0);
		plan(CMD_LOOKUP, 6'd0, 6'd3);
		plan(CMD_LOOKUP, 6'd0, 6'd4);    // rank just past the live count
		plan(CMD_LOOKUP, 6'd0, 6'd63);
		plan(CMD_FREE, 6'd1, 6'd0);
		plan(CMD_FREE, 6'd1, 6'd0);      // same slot again: not in use
		plan(CMD_LOOKUP, 6'd0, 6'd1);    // skips the hole
		plan(CMD_ALLOC, 6'd0, 6'd0);     // refills the hole at slot 1
		plan(CMD_LOOKUP, 6'd0, 6'd1);
		plan(CMD_CLEAR, 6'd63, 6'd63);
		plan(CMD_LOOKUP, 6'd0, 6'd0);
		plan(CMD_ALLOC, 6'd0, 6'd0);     // id counter back at one
		plan(CMD_FREE, 6'd0, 6'd0);
		plan(CMD_FREE, 6'd0, 6'd0);
		plan(CMD_CLEAR, 6'd0, 6'd0);
		plan(CMD_CLEAR, 6'd0, 6'd0);     // clear of an empty pool
		wait_drained();

		// Random: stretches of one command mix, the first one filling the pool
		// past full so that later drains and lookups work on a deep bitmap.
		sent  = 0;
		first = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			kind = first ? PH_FILL : phase_t'($urandom_range(0, 3));
			len  = (kind == PH_NOISE) ? $urandom_range(5, 15) : $urandom_range(30, 80);
			if (first)
				len = 80;
			if (len > RANDOM_ITEMS - sent)
				len = RANDOM_ITEMS - sent;
			calm = ($urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++) begin
				pct = $urandom_range(0, 99);
				case (kind)
					PH_FILL: begin
						if (pct < 92)
							plan(CMD_ALLOC, SLOT_W'($urandom_range(0, 63)),
								RANK_W'($urandom_range(0, 63)));
						else
							plan(CMD_LOOKUP, SLOT_W'($urandom_range(0, 63)), pick_rank());
					end
					PH_DRAIN: begin
						if (pct < 70)
							plan(CMD_FREE, pick_live_slot(), RANK_W'($urandom_range(0, 63)));
						else if (pct < 80)
							plan(CMD_FREE, SLOT_W'($urandom_range(0, 63)),
								RANK_W'($urandom_range(0, 63)));
						else
							plan(CMD_LOOKUP, SLOT_W'($urandom_range(0, 63)), pick_rank());
					end
					PH_MIXED: begin
						if (pct < 35)
							plan(CMD_ALLOC, SLOT_W'($urandom_range(0, 63)),
								RANK_W'($urandom_range(0, 63)));
						else if (pct < 50)
							plan(CMD_FREE, pick_live_slot(), RANK_W'($urandom_range(0, 63)));
						else if (pct < 65)
							plan(CMD_FREE, SLOT_W'($urandom_range(0, 63)),
								RANK_W'($urandom_range(0, 63)));
						else if (pct < 97)
							plan(CMD_LOOKUP, SLOT_W'($urandom_range(0, 63)), pick_rank());
						else
							plan(CMD_CLEAR, SLOT_W'($urandom_range(0, 63)),
								RANK_W'($urandom_range(0, 63)));
					end
					default: begin
						plan(cmd_t'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 63)),
							RANK_W'($urandom_range(0, 63)));
					end
				endcase
			end
			sent += len;
			// Full drain now and then; otherwise keep the driver just fed so
			// the idling mode roughly follows the stretch it was drawn for.
			if (first || $urandom_range(0, 4) == 0)
				wait_drained();
			else
				while (pend_q.size() > 4) @(posedge clk);
			first = 1'b0;
		end

		wait_drained();
		// A late spurious result would still show up in the monitor here.
		repeat (POOL_SLOTS + 16) @(posedge clk);
		if (err_count == 0 && result_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
